### rtl/core/twalc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twalc_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COUNT_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int BIT_CNT_W = 6;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CONFIG_BYTE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_PERIOD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_READY_TIMEOUT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_POWER_DOWN_HOLD = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_POWER_UP_HOLD = 3'd5;

   // link modes, also the status code
   localparam logic [2:0] MODE_SLEEP = 3'd0;
   localparam logic [2:0] MODE_WAIT = 3'd1;
   localparam logic [2:0] MODE_SETTLE = 3'd2;
   localparam logic [2:0] MODE_READY = 3'd3;
   localparam logic [2:0] MODE_ERROR = 3'd4;

   // sequencer steps
   localparam logic [2:0] STEP_IDLE = 3'd0;
   localparam logic [2:0] STEP_DOWN = 3'd1;
   localparam logic [2:0] STEP_UP = 3'd2;
   localparam logic [2:0] STEP_CFG = 3'd3;
   localparam logic [2:0] STEP_READ = 3'd4;

   // configuration write frame
   localparam logic [6:0] WRITE_CMD = 7'h65;
   localparam int DUMMY_CLOCKS = 16 + 13;
   localparam int CMD_BITS = 7;
   localparam int CFG_BITS = 8;
   localparam int CMD_FIRST = DUMMY_CLOCKS;
   localparam int GAP_PULSE = CMD_FIRST + CMD_BITS;
   localparam int CFG_FIRST = GAP_PULSE + 1;
   localparam int CFG_LAST = CFG_FIRST + CFG_BITS - 1;
   localparam int CFG_PULSES = CFG_LAST + 2;

   typedef struct packed {
      logic data_pin;
      logic wake_request;
      logic sleep_request;
   } req_type;

   typedef struct packed {
      logic                       clock_out;
      logic                       data_drive_enable;
      logic                       data_drive_value;
      logic [2:0]                 status;
      logic                       error_code;
      logic                       sample_valid;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [COUNT_W-1:0]         sample_total;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  config_byte;
      logic [7:0]  half_period_ticks;
      logic [23:0] ready_timeout_ticks;
      logic [23:0] settle_ticks;
      logic [15:0] power_down_hold_ticks;
      logic [15:0] power_up_hold_ticks;
   } cfg_type;

   function automatic logic cfg_bit(input logic [BIT_CNT_W-1:0] p,
                                    input logic [7:0] cfg_byte);
      logic [BIT_CNT_W-1:0] cmd_idx;
      logic [BIT_CNT_W-1:0] byte_idx;
      logic                 b;
      cmd_idx = BIT_CNT_W'(GAP_PULSE - 1) - p;
      byte_idx = BIT_CNT_W'(CFG_LAST) - p;
      priority if (p >= BIT_CNT_W'(CMD_FIRST) && p < BIT_CNT_W'(GAP_PULSE)) begin
         b = WRITE_CMD[cmd_idx[2:0]];
      end else if (p == BIT_CNT_W'(GAP_PULSE)) begin
         b = WRITE_CMD[0];
      end else if (p >= BIT_CNT_W'(CFG_FIRST) && p <= BIT_CNT_W'(CFG_LAST)) begin
         b = cfg_byte[byte_idx[2:0]];
      end else begin
         b = 1'b0;
      end
      return b;
   endfunction

endpackage

`default_nettype wire

### rtl/core/twalc_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface twalc_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/twalc_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module twalc_csr
   import twalc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_CONFIG_BYTE:     cfg_in.config_byte = csr_wdata[7:0];
            REG_HALF_PERIOD:     cfg_in.half_period_ticks = csr_wdata[7:0];
            REG_READY_TIMEOUT:   cfg_in.ready_timeout_ticks = csr_wdata[23:0];
            REG_SETTLE:          cfg_in.settle_ticks = csr_wdata[23:0];
            REG_POWER_DOWN_HOLD: cfg_in.power_down_hold_ticks = csr_wdata[15:0];
            REG_POWER_UP_HOLD:   cfg_in.power_up_hold_ticks = csr_wdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.config_byte <= 8'd28;
         cfg_ff.half_period_ticks <= 8'd2;
         cfg_ff.ready_timeout_ticks <= 24'd1000000;
         cfg_ff.settle_ticks <= 24'd80000;
         cfg_ff.power_down_hold_ticks <= 16'd100;
         cfg_ff.power_up_hold_ticks <= 16'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/core/twalc_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module twalc_seq
   import twalc_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int TAIL_CLOCKS = 3,
   parameter int TIMER_BITS = 24
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   localparam logic [BIT_CNT_W-1:0] READ_PULSES = BIT_CNT_W'(SAMPLE_BITS + TAIL_CLOCKS);
   localparam logic [BIT_CNT_W-1:0] CFG_TOTAL = BIT_CNT_W'(CFG_PULSES);
   localparam logic [BIT_CNT_W-1:0] SAMPLE_CNT = BIT_CNT_W'(SAMPLE_BITS);

   logic [2:0]             mode_ff, mode_in;
   logic [2:0]             step_ff, step_in;
   logic [BIT_CNT_W-1:0]   bits_ff, bits_in;
   logic [TIMER_BITS-1:0]  timer_ff, timer_in;
   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic                   configured_ff, configured_in;
   logic                   sleep_pend_ff, sleep_pend_in;
   logic                   wake_pend_ff, wake_pend_in;
   logic [SAMPLE_W-1:0]    last_ff, last_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   clk_ff, clk_in;

   logic [TIMER_BITS-1:0]  timer_inc;
   logic [31:0]            half;
   logic [31:0]            hold;
   logic [BIT_CNT_W-1:0]   total;
   logic [BIT_CNT_W-1:0]   bits_next;
   logic                   valid;
   logic                   drive_en;
   logic                   drive_val;

   function automatic logic reached(input logic [TIMER_BITS-1:0] t, input logic [31:0] limit);
      return (32'(t) >= limit) || (t == '1);
   endfunction

   assign timer_inc = (timer_ff == '1) ? timer_ff : timer_ff + 1'b1;
   assign half = (cfg.half_period_ticks == 8'd0) ? 32'd1 : 32'(cfg.half_period_ticks);
   assign hold = (step_ff == STEP_DOWN) ? 32'(cfg.power_down_hold_ticks)
                                        : 32'(cfg.power_up_hold_ticks);
   assign total = (step_ff == STEP_CFG) ? CFG_TOTAL : READ_PULSES;
   assign bits_next = bits_ff + 1'b1;

   always_comb begin
      mode_in = mode_ff;
      step_in = step_ff;
      bits_in = bits_ff;
      timer_in = timer_ff;
      shift_in = shift_ff;
      configured_in = configured_ff;
      sleep_pend_in = sleep_pend_ff;
      wake_pend_in = wake_pend_ff;
      last_in = last_ff;
      count_in = count_ff;
      clk_in = clk_ff;
      valid = 1'b0;

      if (req.sleep_request) begin
         sleep_pend_in = 1'b1;
         wake_pend_in = 1'b0;
      end
      if (req.wake_request && !sleep_pend_in && mode_ff != MODE_READY
          && mode_ff != MODE_WAIT && mode_ff != MODE_SETTLE) begin
         wake_pend_in = 1'b1;
      end

      unique case (step_ff)
         STEP_IDLE: begin
            priority if (sleep_pend_in) begin
               sleep_pend_in = 1'b0;
               wake_pend_in = 1'b0;
               if (mode_ff != MODE_SLEEP) begin
                  step_in = STEP_DOWN;
                  clk_in = 1'b1;
                  timer_in = '0;
               end
            end else if (wake_pend_in) begin
               wake_pend_in = 1'b0;
               if (mode_ff != MODE_READY) begin
                  step_in = STEP_UP;
                  clk_in = 1'b0;
                  timer_in = '0;
               end
            end else if (mode_ff == MODE_WAIT) begin
               if (!req.data_pin) begin
                  step_in = STEP_CFG;
                  bits_in = '0;
                  timer_in = '0;
                  shift_in = '0;
                  clk_in = 1'b1;
               end else begin
                  timer_in = timer_inc;
                  if (reached(timer_inc, 32'(cfg.ready_timeout_ticks))) begin
                     mode_in = MODE_ERROR;
                  end
               end
            end else if (mode_ff == MODE_SETTLE) begin
               if (reached(timer_ff, 32'(cfg.settle_ticks))) begin
                  mode_in = MODE_READY;
               end else begin
                  timer_in = timer_inc;
               end
            end else if (mode_ff == MODE_READY) begin
               if (!req.data_pin) begin
                  step_in = STEP_READ;
                  bits_in = '0;
                  timer_in = '0;
                  shift_in = '0;
                  clk_in = 1'b1;
               end
            end else begin
               // hold while sleeping or in error
               mode_in = mode_ff;
            end
         end
         STEP_DOWN, STEP_UP: begin
            if (reached(timer_ff, hold)) begin
               if (step_ff == STEP_DOWN) begin
                  mode_in = MODE_SLEEP;
               end else begin
                  mode_in = configured_ff ? MODE_SETTLE : MODE_WAIT;
               end
               step_in = STEP_IDLE;
               timer_in = '0;
            end else begin
               timer_in = timer_inc;
            end
         end
         STEP_CFG, STEP_READ: begin
            timer_in = timer_inc;
            if (32'(timer_inc) >= half) begin
               timer_in = '0;
               if (clk_ff) begin
                  clk_in = 1'b0;
                  if (step_ff == STEP_READ && bits_ff < SAMPLE_CNT) begin
                     shift_in = {shift_ff[SAMPLE_BITS-2:0], req.data_pin};
                  end
               end else begin
                  bits_in = bits_next;
                  if (bits_next < total) begin
                     clk_in = 1'b1;
                  end else if (step_ff == STEP_CFG) begin
                     configured_in = 1'b1;
                     mode_in = MODE_SETTLE;
                     step_in = STEP_IDLE;
                     bits_in = '0;
                  end else begin
                     last_in = SAMPLE_W'($signed(shift_ff));
                     count_in = count_ff + 1'b1;
                     valid = 1'b1;
                     step_in = STEP_IDLE;
                     bits_in = '0;
                  end
               end
            end
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase
   end

   assign drive_en = (step_in == STEP_CFG) && (bits_in >= BIT_CNT_W'(CMD_FIRST))
                     && (bits_in <= BIT_CNT_W'(CFG_LAST));
   assign drive_val = drive_en ? cfg_bit(bits_in, cfg.config_byte) : 1'b0;

   always_comb begin
      rsp.clock_out = clk_in;
      rsp.data_drive_enable = drive_en;
      rsp.data_drive_value = drive_val;
      rsp.status = mode_in;
      rsp.error_code = (mode_in == MODE_ERROR);
      rsp.sample_valid = valid;
      rsp.sample_value = last_in;
      rsp.sample_total = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SLEEP;
         step_ff <= STEP_IDLE;
         bits_ff <= '0;
         timer_ff <= '0;
         shift_ff <= '0;
         configured_ff <= 1'b0;
         sleep_pend_ff <= 1'b0;
         wake_pend_ff <= 1'b0;
         last_ff <= '0;
         count_ff <= '0;
         clk_ff <= 1'b1;
      end else if (advance) begin
         mode_ff <= mode_in;
         step_ff <= step_in;
         bits_ff <= bits_in;
         timer_ff <= timer_in;
         shift_ff <= shift_in;
         configured_ff <= configured_in;
         sleep_pend_ff <= sleep_pend_in;
         wake_pend_ff <= wake_pend_in;
         last_ff <= last_in;
         count_ff <= count_in;
         clk_ff <= clk_in;
      end
   end

`ifndef SYNTH
   a_drive_in_wait: assert property (@(posedge clock) disable iff (reset)
      drive_en |-> mode_in == MODE_WAIT)
      else $error("config drive outside wait mode");

   a_sample_in_ready: assert property (@(posedge clock) disable iff (reset)
      valid |-> mode_ff == MODE_READY && step_ff == STEP_READ)
      else $error("sample completed outside a read");

   a_count_bump: assert property (@(posedge clock) disable iff (reset)
      advance && valid |=> count_ff == $past(count_ff) + 1'b1)
      else $error("sample count did not advance");

   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= CFG_TOTAL)
      else $error("bit counter out of range");

   a_error_step: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ERROR |-> step_ff == STEP_IDLE || step_ff == STEP_DOWN
                                || step_ff == STEP_UP)
      else $error("sequence running in error mode");
`endif

endmodule

`default_nettype wire

### rtl/core/two_wire_adc_link_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-wire load-cell ADC link controller. Each req item is one timebase tick
// carrying the sampled data line and the wake/sleep requests; each tick gives
// exactly one rsp item with the clock and data line levels to drive, the link
// status and the latest sample. One item is taken per clock cycle while rsp_chan
// is not stalled; an item passes an input register and then a result register,
// from which its rsp item is offered on rsp_chan. The link state advances only
// when an item moves from the input register into the result register.
// Write the csr_ registers only while no item is in flight.
module two_wire_adc_link_controller_unit
   import twalc_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int TAIL_CLOCKS = 3,
   parameter int TIMER_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   twalc_chan_if.sink                  req_chan,
   twalc_chan_if.source                rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type req_ff, req_in;
   logic    req_vld_ff, req_vld_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type rsp_next;
   logic    rsp_vld_ff, rsp_vld_in;
   logic    advance;
   logic    req_ready;

   twalc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   twalc_seq #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TAIL_CLOCKS (TAIL_CLOCKS),
      .TIMER_BITS  (TIMER_BITS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_next)
   );

   assign advance = req_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_ready = !req_vld_ff || advance;
   assign req_chan.ready = req_ready;

   always_comb begin
      req_vld_in = req_ready ? req_chan.valid : req_vld_ff;
      req_in = (req_ready && req_chan.valid) ? req_chan.data : req_ff;
      rsp_vld_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_vld_ff);
      rsp_in = advance ? rsp_next : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data = rsp_ff;

`ifndef SYNTH
   a_adv_needs_item: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("result register not loaded on advance");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      req_vld_ff && rsp_vld_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("item taken while both stages are full");

   a_error_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_ff.error_code == (rsp_ff.status == MODE_ERROR))
      else $error("error code disagrees with status");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import twalc_pkg::*;

   localparam int READ_BITS = 24;
   localparam int READ_PULSES = READ_BITS + 3;
   localparam logic [23:0] TIMER_MAX = 24'hFFFFFF;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   // pin wake sleep | typed | clock status error
   localparam logic [8:0] SCRIPT [19] = '{
      {3'b100, 1'b1, 1'b1, MODE_SLEEP, 1'b0},
      {3'b101, 1'b1, 1'b1, MODE_SLEEP, 1'b0},
      {3'b110, 1'b0, 1'b0, MODE_SLEEP, 1'b0},
      {3'b100, 1'b0, 1'b0, MODE_SLEEP, 1'b0},
      {3'b100, 1'b0, 1'b0, MODE_SLEEP, 1'b0},
      {3'b100, 1'b0, 1'b0, MODE_SLEEP, 1'b0},
      {3'b100, 1'b0, 1'b0, MODE_SLEEP, 1'b0},
      {3'b100, 1'b1, 1'b0, MODE_ERROR, 1'b1},
      {3'b000, 1'b1, 1'b0, MODE_ERROR, 1'b1},
      {3'b111, 1'b1, 1'b1, MODE_ERROR, 1'b1},
      {3'b000, 1'b1, 1'b1, MODE_ERROR, 1'b1},
      {3'b000, 1'b1, 1'b1, MODE_ERROR, 1'b1},
      {3'b000, 1'b1, 1'b1, MODE_SLEEP, 1'b0},
      {3'b010, 1'b0, 1'b0, MODE_SLEEP, 1'b0},
      {3'b000, 1'b0, 1'b0, MODE_SLEEP, 1'b0},
      {3'b000, 1'b0, 1'b0, MODE_SLEEP, 1'b0},
      {3'b000, 1'b0, 1'b0, MODE_SLEEP, 1'b0},
      {3'b110, 1'b0, 1'b0, MODE_SLEEP, 1'b0},
      {3'b001, 1'b0, 1'b0, MODE_SLEEP, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   twalc_chan_if #(.payload_type(req_type)) req_chan ();
   twalc_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   two_wire_adc_link_controller_unit dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cfg_type link_cfg;
   logic [2:0] link_mode;
   logic [2:0] link_step;
   logic [5:0] pulse_count;
   logic [23:0] tick_count;
   logic [SAMPLE_W-1:0] sample_shift;
   logic [SAMPLE_W-1:0] sample_latch;
   logic [COUNT_W-1:0] reads_done;
   logic configured;
   logic sleep_pending;
   logic wake_pending;
   logic clock_level;
   logic [SAMPLE_W-1:0] read_pattern;

   rsp_type predicted_outputs [$];
   int unsigned mismatches = 0;
   int unsigned result_index = 0;
   bit steady_flow = 1'b0;

   task automatic flag_mismatch(input string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                 result_index, name, got, want));
   endtask

   function automatic bit timer_done(input logic [23:0] limit);
      return tick_count >= limit || tick_count == TIMER_MAX;
   endfunction

   function automatic void bump_timer();
      if (tick_count != TIMER_MAX)
         tick_count++;
   endfunction

   function automatic void begin_pulses(input logic [2:0] step);
      link_step = step;
      pulse_count = '0;
      tick_count = '0;
      sample_shift = '0;
      clock_level = 1'b1;
   endfunction

   // advance the link by one tick and return the pin levels and status it shows
   function automatic rsp_type step_link(input req_type t);
      rsp_type view;
      logic [7:0] half;
      logic [23:0] hold;
      logic [15:0] frame;
      int total;
      bit done;
      view = '0;
      done = 1'b0;
      half = (link_cfg.half_period_ticks == 8'd0) ? 8'd1 : link_cfg.half_period_ticks;
      if (t.sleep_request) begin
         sleep_pending = 1'b1;
         wake_pending = 1'b0;
      end
      if (t.wake_request && !sleep_pending && link_mode != MODE_READY &&
          link_mode != MODE_WAIT && link_mode != MODE_SETTLE)
         wake_pending = 1'b1;

      if (link_step == STEP_IDLE) begin
         if (sleep_pending) begin
            sleep_pending = 1'b0;
            wake_pending = 1'b0;
            if (link_mode != MODE_SLEEP) begin
               link_step = STEP_DOWN;
               clock_level = 1'b1;
               tick_count = '0;
            end
         end else if (wake_pending) begin
            wake_pending = 1'b0;
            if (link_mode != MODE_READY) begin
               link_step = STEP_UP;
               clock_level = 1'b0;
               tick_count = '0;
            end
         end else if (link_mode == MODE_WAIT) begin
            if (!t.data_pin) begin
               begin_pulses(STEP_CFG);
            end else begin
               bump_timer();
               if (timer_done(link_cfg.ready_timeout_ticks))
                  link_mode = MODE_ERROR;
            end
         end else if (link_mode == MODE_SETTLE) begin
            if (timer_done(link_cfg.settle_ticks))
               link_mode = MODE_READY;
            else
               bump_timer();
         end else if (link_mode == MODE_READY && !t.data_pin) begin
            begin_pulses(STEP_READ);
         end
      end else if (link_step == STEP_DOWN || link_step == STEP_UP) begin
         hold = (link_step == STEP_DOWN) ? 24'(link_cfg.power_down_hold_ticks)
                                         : 24'(link_cfg.power_up_hold_ticks);
         if (timer_done(hold)) begin
            if (link_step == STEP_DOWN)
               link_mode = MODE_SLEEP;
            else
               link_mode = configured ? MODE_SETTLE : MODE_WAIT;
            link_step = STEP_IDLE;
            tick_count = '0;
         end else begin
            bump_timer();
         end
      end else begin
         total = (link_step == STEP_CFG) ? CFG_PULSES : READ_PULSES;
         bump_timer();
         if (tick_count >= 24'(half)) begin
            tick_count = '0;
            if (clock_level) begin
               clock_level = 1'b0;
               if (link_step == STEP_READ && int'(pulse_count) < READ_BITS)
                  sample_shift = {sample_shift[SAMPLE_W-2:0], t.data_pin};
            end else begin
               pulse_count++;
               if (int'(pulse_count) < total) begin
                  clock_level = 1'b1;
               end else begin
                  if (link_step == STEP_CFG) begin
                     configured = 1'b1;
                     link_mode = MODE_SETTLE;
                  end else begin
                     sample_latch = sample_shift;
                     reads_done++;
                     done = 1'b1;
                  end
                  link_step = STEP_IDLE;
                  pulse_count = '0;
               end
            end
         end
      end

      if (link_step == STEP_CFG && int'(pulse_count) >= CMD_FIRST &&
          int'(pulse_count) <= CFG_LAST) begin
         // command, its last bit again for the gap clock, then the byte
         frame = {WRITE_CMD, WRITE_CMD[0], link_cfg.config_byte};
         view.data_drive_enable = 1'b1;
         view.data_drive_value = frame[4'(CFG_LAST - int'(pulse_count))];
      end
      view.clock_out = clock_level;
      view.status = link_mode;
      view.error_code = (link_mode == MODE_ERROR);
      view.sample_valid = done;
      view.sample_value = sample_latch;
      view.sample_total = reads_done;
      return view;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_CONFIG_BYTE: link_cfg.config_byte = value[7:0];
         REG_HALF_PERIOD: link_cfg.half_period_ticks = value[7:0];
         REG_READY_TIMEOUT: link_cfg.ready_timeout_ticks = value;
         REG_SETTLE: link_cfg.settle_ticks = value;
         REG_POWER_DOWN_HOLD: link_cfg.power_down_hold_ticks = value[15:0];
         REG_POWER_UP_HOLD: link_cfg.power_up_hold_ticks = value[15:0];
         default: ;
      endcase
   endtask

   task automatic send_tick(input req_type t, input bit typed, input rsp_type want);
      rsp_type view;
      req_chan.valid <= 1'b1;
      req_chan.data <= t;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      view = step_link(t);
      predicted_outputs.push_back(typed ? want : view);
      if (!steady_flow && $urandom_range(4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (predicted_outputs.size() != 0)
         @(posedge clock);
   endtask

   // ADC-like line: sample bits during a read, mostly high while waiting, random otherwise
   task automatic run_random(input int unsigned count, input int unsigned sleep_odds);
      req_type t;
      for (int unsigned n = 0; n < count; n++) begin
         if (link_step != STEP_READ) begin
            case ($urandom_range(7))
               0: read_pattern = 24'h000000;
               1: read_pattern = 24'hFFFFFF;
               2: read_pattern = 24'h800000;
               3: read_pattern = 24'h7FFFFF;
               default: read_pattern = 24'($urandom);
            endcase
         end
         t.sleep_request = sleep_odds != 0 && $urandom_range(sleep_odds - 1) == 0;
         if (link_mode == MODE_SLEEP || link_mode == MODE_ERROR)
            t.wake_request = $urandom_range(3) == 0;
         else
            t.wake_request = $urandom_range(15) == 0;
         if (link_step == STEP_READ && int'(pulse_count) < READ_BITS)
            t.data_pin = read_pattern[5'(READ_BITS - 1 - int'(pulse_count))];
         else if (link_mode == MODE_WAIT && link_step == STEP_IDLE)
            t.data_pin = $urandom_range(5) != 0;
         else
            t.data_pin = $urandom_range(2) != 0;
         send_tick(t, 1'b0, '0);
      end
   endtask

   initial begin
      int unsigned stall_left;
      rsp_type want;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (predicted_outputs.size() == 0) begin
               flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                       result_index));
            end else begin
               want = predicted_outputs.pop_front();
               check_field("clock_out", rsp_chan.data.clock_out, want.clock_out);
               check_field("data_drive_enable", rsp_chan.data.data_drive_enable,
                           want.data_drive_enable);
               check_field("data_drive_value", rsp_chan.data.data_drive_value,
                           want.data_drive_value);
               check_field("status", rsp_chan.data.status, want.status);
               check_field("error_code", rsp_chan.data.error_code, want.error_code);
               check_field("sample_valid", rsp_chan.data.sample_valid, want.sample_valid);
               check_field("sample_value", rsp_chan.data.sample_value, want.sample_value);
               check_field("sample_total", rsp_chan.data.sample_total, want.sample_total);
            end
            result_index++;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            if (!steady_flow && stall_left == 0 && $urandom_range(5) == 0)
               stall_left = $urandom_range(1, 5);
            if (!steady_flow && stall_left != 0) begin
               rsp_chan.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("two_wire_adc_link_controller_unit: mismatch");
      $finish;
   end

   initial begin
      req_type row_req;
      bit row_typed;
      logic row_clk;
      logic [2:0] row_status;
      logic row_err;
      req_type t;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      link_cfg = '{config_byte: 8'd28, half_period_ticks: 8'd2,
                   ready_timeout_ticks: 24'd1000000, settle_ticks: 24'd80000,
                   power_down_hold_ticks: 16'd100, power_up_hold_ticks: 16'd10};
      link_mode = MODE_SLEEP;
      link_step = STEP_IDLE;
      pulse_count = '0;
      tick_count = '0;
      sample_shift = '0;
      sample_latch = '0;
      reads_done = '0;
      configured = 1'b0;
      sleep_pending = 1'b0;
      wake_pending = 1'b0;
      clock_level = 1'b1;
      read_pattern = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_reg(REG_SPARE_LO, 24'hFFFFFF);
      write_reg(REG_SPARE_HI, 24'h5A5A5A);
      write_reg(REG_CONFIG_BYTE, 24'hA5);
      write_reg(REG_HALF_PERIOD, 24'd1);
      write_reg(REG_READY_TIMEOUT, 24'd3);
      write_reg(REG_SETTLE, 24'd4);
      write_reg(REG_POWER_DOWN_HOLD, 24'd2);
      write_reg(REG_POWER_UP_HOLD, 24'd1);

      for (int i = 0; i < $size(SCRIPT); i++) begin
         {row_req, row_typed, row_clk, row_status, row_err} = SCRIPT[i];
         send_tick(row_req, row_typed,
                   {row_clk, 2'b00, row_status, row_err, 1'b0, 24'd0, 32'd0});
      end
      drain_results();
      run_random(200, 120);
      drain_results();

      // zero half period, shortest waits
      write_reg(REG_CONFIG_BYTE, 24'h00);
      write_reg(REG_HALF_PERIOD, 24'd0);
      write_reg(REG_READY_TIMEOUT, 24'd1);
      write_reg(REG_SETTLE, 24'd0);
      write_reg(REG_POWER_DOWN_HOLD, 24'd0);
      write_reg(REG_POWER_UP_HOLD, 24'd0);
      run_random(200, 60);
      drain_results();

      // longest clock half period
      write_reg(REG_CONFIG_BYTE, 24'hFF);
      write_reg(REG_HALF_PERIOD, 24'd255);
      write_reg(REG_READY_TIMEOUT, 24'd40);
      write_reg(REG_SETTLE, 24'd20);
      write_reg(REG_POWER_DOWN_HOLD, 24'd5);
      write_reg(REG_POWER_UP_HOLD, 24'd5);
      run_random(150, 0);
      drain_results();

      // park in a long settle, then sleep through a long power-down hold
      write_reg(REG_HALF_PERIOD, 24'd3);
      write_reg(REG_READY_TIMEOUT, 24'hFFFFFF);
      write_reg(REG_SETTLE, 24'hFFFFFF);
      write_reg(REG_POWER_DOWN_HOLD, 24'd120);
      while (!(link_step == STEP_IDLE &&
               (link_mode == MODE_SETTLE || link_mode == MODE_READY))) begin
         t = '{data_pin: link_mode != MODE_WAIT, wake_request: 1'b1, sleep_request: 1'b0};
         send_tick(t, 1'b0, '0);
      end
      send_tick('{data_pin: 1'b1, wake_request: 1'b0, sleep_request: 1'b1}, 1'b0, '0);
      while (!(link_step == STEP_IDLE && link_mode == MODE_SLEEP)) begin
         t = '{data_pin: 1'($urandom), wake_request: 1'b0, sleep_request: 1'b0};
         send_tick(t, 1'b0, '0);
      end
      drain_results();

      // long power-up hold
      write_reg(REG_POWER_UP_HOLD, 24'd120);
      write_reg(REG_POWER_DOWN_HOLD, 24'd3);
      while (!(link_step == STEP_IDLE && link_mode == MODE_SETTLE))
         send_tick('{data_pin: 1'b1, wake_request: 1'b1, sleep_request: 1'b0}, 1'b0, '0);
      run_random(100, 0);
      drain_results();

      write_reg(REG_CONFIG_BYTE, 24'h5A);
      write_reg(REG_HALF_PERIOD, 24'd2);
      write_reg(REG_READY_TIMEOUT, 24'd50);
      write_reg(REG_SETTLE, 24'd10);
      write_reg(REG_POWER_DOWN_HOLD, 24'd4);
      write_reg(REG_POWER_UP_HOLD, 24'd2);
      run_random(300, 100);
      drain_results();

      // full rate on both sides
      steady_flow = 1'b1;
      write_reg(REG_HALF_PERIOD, 24'd1);
      write_reg(REG_SETTLE, 24'd3);
      run_random(250, 150);
      drain_results();
      repeat (8) @(posedge clock);

      if (predicted_outputs.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", predicted_outputs.size()));
      if (mismatches == 0)
         $display("two_wire_adc_link_controller_unit: match");
      else
         $display("two_wire_adc_link_controller_unit: mismatch");
      $finish;
   end

endmodule
